### src/tdkbm_pkg.sv
package tdkbm_pkg;

    // Sequencer step codes beyond the microprogram.
    localparam int unsigned PROG_LEN = 26;
    localparam logic [4:0] SEQ_KEY  = 5'd29;
    localparam logic [4:0] SEQ_DONE = 5'd30;
    localparam logic [4:0] SEQ_IDLE = 5'd31;

    // Entry points of each command into the microprogram.
    localparam logic [4:0] ENTRY_START = 5'd0;
    localparam logic [4:0] ENTRY_ACK   = 5'd2;
    localparam logic [4:0] ENTRY_STOP  = 5'd5;
    localparam logic [4:0] ENTRY_WRITE = 5'd9;
    localparam logic [4:0] ENTRY_READ  = 5'd11;

    localparam logic [7:0] KEY_CMD_BYTE  = 8'h42;
    localparam logic [7:0] SAMPLE_MSB    = 8'h80;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [7:0] TICKS_RESET   = 8'd40;

    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_START = 3'd1,
        ACT_WRITE = 3'd2,
        ACT_ACK   = 3'd3,
        ACT_STOP  = 3'd4,
        ACT_READ  = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        PIN_LO   = 2'd0,
        PIN_HI   = 2'd1,
        PIN_KEEP = 2'd2
    } pin_op_t;

    typedef enum logic [2:0] {
        SH_NONE   = 3'd0,
        SH_BIT    = 3'd1,
        SH_LOAD   = 3'd2,
        SH_CLEAR  = 3'd3,
        SH_SHR    = 3'd4,
        SH_SAMPLE = 3'd5
    } shift_op_t;

    typedef enum logic [2:0] {
        FL_NEXT      = 3'd0,
        FL_END       = 3'd1,
        FL_KEY       = 3'd2,
        FL_LOOP_NEXT = 3'd3,
        FL_LOOP_END  = 3'd4
    } flow_op_t;

    typedef struct packed {
        pin_op_t   clk;
        pin_op_t   dio;
        logic      wait_ack;
        shift_op_t sh;
        logic [4:0] us;
        flow_op_t  flow;
        logic [4:0] target;
    } micro_op_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic       dio_in;
    } in_t;

    typedef struct packed {
        logic       clk_level;
        logic       dio_level;
        logic       busy_res;
        logic       key_valid;
        logic [7:0] key_code;
        logic       rejected;
    } out_t;

    // Classified item handed from the front end to the sequencer.
    typedef struct packed {
        logic       is_cmd;
        logic       is_write;
        logic [4:0] entry_step;
        logic [7:0] data_byte;
        logic       dio_in;
    } item_t;

    function automatic logic [4:0] entry_of(input logic [2:0] action);
        logic [4:0] e;
        case (action)
            ACT_START: e = ENTRY_START;
            ACT_WRITE: e = ENTRY_WRITE;
            ACT_ACK:   e = ENTRY_ACK;
            ACT_STOP:  e = ENTRY_STOP;
            ACT_READ:  e = ENTRY_READ;
            default:   e = SEQ_IDLE;
        endcase
        return e;
    endfunction

    function automatic micro_op_t mop(input pin_op_t c, input pin_op_t d, input logic w,
                                      input shift_op_t s, input logic [4:0] u,
                                      input flow_op_t f, input logic [4:0] t);
        micro_op_t m;
        m.clk = c;
        m.dio = d;
        m.wait_ack = w;
        m.sh = s;
        m.us = u;
        m.flow = f;
        m.target = t;
        return m;
    endfunction

    // Pin microprogram: start, acknowledge, stop, write byte, read key.
    function automatic micro_op_t prog_op(input logic [4:0] step);
        micro_op_t m;
        case (step)
            5'd0:  m = mop(PIN_HI,   PIN_HI,   1'b0, SH_NONE,   5'd2,  FL_NEXT,      5'd0);
            5'd1:  m = mop(PIN_KEEP, PIN_LO,   1'b0, SH_NONE,   5'd0,  FL_END,       5'd0);
            5'd2:  m = mop(PIN_LO,   PIN_KEEP, 1'b0, SH_NONE,   5'd5,  FL_NEXT,      5'd0);
            5'd3:  m = mop(PIN_HI,   PIN_KEEP, 1'b1, SH_NONE,   5'd2,  FL_NEXT,      5'd0);
            5'd4:  m = mop(PIN_LO,   PIN_KEEP, 1'b0, SH_NONE,   5'd0,  FL_END,       5'd0);
            5'd5:  m = mop(PIN_LO,   PIN_KEEP, 1'b0, SH_NONE,   5'd2,  FL_NEXT,      5'd0);
            5'd6:  m = mop(PIN_KEEP, PIN_LO,   1'b0, SH_NONE,   5'd2,  FL_NEXT,      5'd0);
            5'd7:  m = mop(PIN_HI,   PIN_KEEP, 1'b0, SH_NONE,   5'd2,  FL_NEXT,      5'd0);
            5'd8:  m = mop(PIN_KEEP, PIN_HI,   1'b0, SH_NONE,   5'd0,  FL_END,       5'd0);
            5'd9:  m = mop(PIN_LO,   PIN_KEEP, 1'b0, SH_BIT,    5'd3,  FL_NEXT,      5'd0);
            5'd10: m = mop(PIN_HI,   PIN_KEEP, 1'b0, SH_NONE,   5'd3,  FL_LOOP_END,  5'd9);
            5'd11: m = mop(PIN_HI,   PIN_HI,   1'b0, SH_NONE,   5'd2,  FL_NEXT,      5'd0);
            5'd12: m = mop(PIN_KEEP, PIN_LO,   1'b0, SH_LOAD,   5'd0,  FL_NEXT,      5'd0);
            5'd13: m = mop(PIN_LO,   PIN_KEEP, 1'b0, SH_BIT,    5'd3,  FL_NEXT,      5'd0);
            5'd14: m = mop(PIN_HI,   PIN_KEEP, 1'b0, SH_NONE,   5'd3,  FL_LOOP_NEXT, 5'd13);
            5'd15: m = mop(PIN_LO,   PIN_KEEP, 1'b0, SH_NONE,   5'd5,  FL_NEXT,      5'd0);
            5'd16: m = mop(PIN_HI,   PIN_KEEP, 1'b1, SH_NONE,   5'd2,  FL_NEXT,      5'd0);
            5'd17: m = mop(PIN_LO,   PIN_HI,   1'b0, SH_CLEAR,  5'd0,  FL_NEXT,      5'd0);
            5'd18: m = mop(PIN_LO,   PIN_KEEP, 1'b0, SH_SHR,    5'd30, FL_NEXT,      5'd0);
            5'd19: m = mop(PIN_HI,   PIN_KEEP, 1'b0, SH_SAMPLE, 5'd30, FL_LOOP_NEXT, 5'd18);
            5'd20: m = mop(PIN_LO,   PIN_KEEP, 1'b0, SH_NONE,   5'd5,  FL_NEXT,      5'd0);
            5'd21: m = mop(PIN_HI,   PIN_KEEP, 1'b1, SH_NONE,   5'd2,  FL_NEXT,      5'd0);
            5'd22: m = mop(PIN_LO,   PIN_KEEP, 1'b0, SH_NONE,   5'd2,  FL_NEXT,      5'd0);
            5'd23: m = mop(PIN_KEEP, PIN_LO,   1'b0, SH_NONE,   5'd2,  FL_NEXT,      5'd0);
            5'd24: m = mop(PIN_HI,   PIN_KEEP, 1'b0, SH_NONE,   5'd2,  FL_NEXT,      5'd0);
            5'd25: m = mop(PIN_KEEP, PIN_HI,   1'b0, SH_NONE,   5'd0,  FL_KEY,       5'd0);
            default: m = mop(PIN_KEEP, PIN_KEEP, 1'b0, SH_NONE, 5'd0,  FL_NEXT,      5'd0);
        endcase
        return m;
    endfunction

endpackage

### src/tdkbm_front.sv
module tdkbm_front import tdkbm_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  in_t   s_data,
    output logic  q_valid,
    output item_t q_item,
    input  logic  q_pop
);

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW = $clog2(Q_DEPTH);

    item_t              item_mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]    wr_ptr_reg;
    logic [Q_AW-1:0]    rd_ptr_reg;
    logic [Q_AW:0]      count_reg;
    item_t              item_in;
    logic               push;
    logic               pop;

    always_comb begin
        item_in.is_cmd     = (s_data.action >= ACT_START) && (s_data.action <= ACT_READ);
        item_in.is_write   = (s_data.action == ACT_WRITE);
        item_in.entry_step = entry_of(s_data.action);
        item_in.data_byte  = s_data.data_byte;
        item_in.dio_in     = s_data.dio_in;
    end

    assign s_ready = (count_reg != (Q_AW+1)'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = item_mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            item_mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

### src/tdkbm_seq.sv
module tdkbm_seq import tdkbm_pkg::*; #(
    parameter int unsigned DELAY_WIDTH = 13
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] ticks_per_us,
    input  logic       q_valid,
    input  item_t      q_item,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_data
);

    localparam int unsigned PROD_W = 13;
    localparam int unsigned WIDE_W = (DELAY_WIDTH > PROD_W) ? DELAY_WIDTH : PROD_W;

    logic [4:0]             step_reg;
    logic [DELAY_WIDTH-1:0] delay_reg;
    logic [3:0]             bit_reg;
    logic [7:0]             shift_reg;
    logic                   clk_reg;
    logic                   dio_reg;
    logic                   run_reg;
    logic                   rej_reg;
    logic                   m_valid_reg;
    out_t                   m_data_reg;

    logic [4:0]             base_step;
    logic [DELAY_WIDTH-1:0] base_delay;
    logic [3:0]             base_bit;
    logic [7:0]             base_shift;
    logic [4:0]             step_next;
    logic [DELAY_WIDTH-1:0] delay_next;
    logic [3:0]             bit_next;
    logic [7:0]             shift_next;
    logic                   clk_next;
    logic                   dio_next;
    logic                   rej;
    logic                   exec;
    logic                   finish;
    logic                   key;
    logic                   go;
    micro_op_t              op;
    logic [PROD_W-1:0]      prod;
    logic [WIDE_W-1:0]      prod_wide;
    logic [WIDE_W-1:0]      max_wide;
    logic [DELAY_WIDTH-1:0] op_delay;
    out_t                   result;

    assign go = q_valid && (!m_valid_reg || m_ready);

    always_comb begin
        // First cycle of an item does the tick bookkeeping; later cycles
        // only walk the zero-delay steps that follow.
        base_step  = step_reg;
        base_delay = delay_reg;
        base_bit   = bit_reg;
        base_shift = shift_reg;
        rej        = rej_reg;
        exec       = 1'b1;
        if (!run_reg) begin
            rej = 1'b0;
            if (step_reg != SEQ_IDLE) begin
                rej = q_item.is_cmd;
                if (delay_reg != '0) begin
                    base_delay = delay_reg - 1'b1;
                end
                exec = (base_delay == '0);
            end else if (q_item.is_cmd) begin
                base_step  = q_item.entry_step;
                base_bit   = '0;
                base_shift = q_item.is_write ? q_item.data_byte : 8'h00;
                base_delay = '0;
            end else begin
                exec = 1'b0;
            end
        end

        op        = prog_op(base_step);
        prod      = PROD_W'(op.us) * PROD_W'(ticks_per_us);
        prod_wide = WIDE_W'(prod);
        max_wide  = WIDE_W'({DELAY_WIDTH{1'b1}});
        op_delay  = (prod_wide > max_wide) ? DELAY_WIDTH'(max_wide)
                                           : DELAY_WIDTH'(prod_wide);

        step_next  = base_step;
        delay_next = base_delay;
        bit_next   = base_bit;
        shift_next = base_shift;
        clk_next   = clk_reg;
        dio_next   = dio_reg;
        key        = 1'b0;
        finish     = 1'b1;

        if (exec) begin
            if (base_step >= 5'(PROG_LEN)) begin
                step_next = SEQ_IDLE;
                key       = (base_step == SEQ_KEY);
            end else if (!(op.wait_ack && q_item.dio_in)) begin
                if (op.clk != PIN_KEEP) begin
                    clk_next = (op.clk == PIN_HI);
                end
                if (op.dio != PIN_KEEP) begin
                    dio_next = (op.dio == PIN_HI);
                end
                case (op.sh)
                    SH_BIT: begin
                        dio_next   = base_shift[0];
                        shift_next = base_shift >> 1;
                    end
                    SH_LOAD: begin
                        shift_next = KEY_CMD_BYTE;
                        bit_next   = '0;
                    end
                    SH_CLEAR: begin
                        shift_next = 8'h00;
                        bit_next   = '0;
                    end
                    SH_SHR: begin
                        shift_next = base_shift >> 1;
                    end
                    SH_SAMPLE: begin
                        if (q_item.dio_in) begin
                            shift_next = base_shift | SAMPLE_MSB;
                        end
                    end
                    default: begin
                    end
                endcase
                step_next = 5'(base_step + 5'd1);
                case (op.flow)
                    FL_END: begin
                        step_next = SEQ_DONE;
                    end
                    FL_KEY: begin
                        step_next = SEQ_KEY;
                    end
                    FL_LOOP_NEXT, FL_LOOP_END: begin
                        bit_next = 4'(bit_next + 4'd1);
                        if (bit_next < BITS_PER_BYTE) begin
                            step_next = op.target;
                        end else begin
                            bit_next = '0;
                            if (op.flow == FL_LOOP_END) begin
                                step_next = SEQ_DONE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                delay_next = op_delay;
                finish     = (op_delay != '0);
            end
        end

        result.clk_level = clk_next;
        result.dio_level = dio_next;
        result.busy_res  = (step_next != SEQ_IDLE);
        result.key_valid = key;
        result.key_code  = key ? shift_next : 8'h00;
        result.rejected  = rej;
    end

    assign q_pop   = go && finish;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= SEQ_IDLE;
            delay_reg   <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            clk_reg     <= 1'b1;
            dio_reg     <= 1'b1;
            run_reg     <= 1'b0;
            rej_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (go && finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (go) begin
                step_reg  <= step_next;
                delay_reg <= delay_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                clk_reg   <= clk_next;
                dio_reg   <= dio_next;
                rej_reg   <= rej;
                run_reg   <= !finish;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go && finish) begin
            m_data_reg <= result;
        end
    end

endmodule

### src/two_wire_display_key_bus_master_unit.sv
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   in_t: action, data_byte, dio_in
// m_        out        m_valid / m_ready   out_t: pin levels, busy, key, reject
// cfg_      in         cfg_wr_en           cfg_wr_data: ticks per microsecond
//
// An item stays in the sequencer for its first step and for each further
// zero-delay microprogram step it runs (a step ends in zero delay when its
// time is zero or ticks_per_us is zero); the sequencer walks one step a cycle while the output is not stalled.
// A four-entry queue sits between the input and the sequencer, and results
// leave through an output register. Reset is synchronous and active low.
// A stalled output holds the sequencer; the queue keeps taking items until
// it is full.
module two_wire_display_key_bus_master_unit import tdkbm_pkg::*; #(
    parameter int unsigned DELAY_WIDTH = 13
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_t        s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_data,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    logic [7:0] ticks_reg;
    logic       q_valid;
    item_t      q_item;
    logic       q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= TICKS_RESET;
        end else if (cfg_wr_en) begin
            ticks_reg <= cfg_wr_data;
        end
    end

    tdkbm_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    tdkbm_seq #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ticks_per_us (ticks_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

### sim/two_wire_display_key_bus_master_unit_tb.sv
`timescale 1ns / 100ps

module two_wire_display_key_bus_master_unit_tb;
    import tdkbm_pkg::*;

    localparam int          DELAY_W        = 13;
    localparam int unsigned DELAY_MAX      = (1 << DELAY_W) - 1;
    localparam int          SETTLE_CYCLES  = 120;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          REPORT_LIMIT   = 10;
    // Codes outside the command set; the block treats them as ticks.
    localparam logic [2:0]  ACT_SPARE_LO   = 3'd6;
    localparam logic [2:0]  ACT_SPARE_HI   = 3'd7;

    logic       aclk;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    in_t        s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    out_t       m_data;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = '0;

    two_wire_display_key_bus_master_unit #(.DELAY_WIDTH(DELAY_W)) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Pin sequencer mirror.
    micro_op_t          step_rom [PROG_LEN];
    logic [4:0]         seq_pos;
    logic [DELAY_W-1:0] delay_left;
    logic [3:0]         bit_cnt;
    logic [7:0]         shifter;
    logic               clk_q;
    logic               dio_q;
    logic [7:0]         tick_rate;

    out_t expected_pins [$];
    out_t want;
    int   fail_count;
    int   items_sent;
    int   idle_pct;
    bit   tail_phase;
    int   stall_left;
    int   quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        step_rom[0]  = {PIN_HI,   PIN_HI,   1'b0, SH_NONE,   5'd2,  FL_NEXT,      5'd0};
        step_rom[1]  = {PIN_KEEP, PIN_LO,   1'b0, SH_NONE,   5'd0,  FL_END,       5'd0};
        step_rom[2]  = {PIN_LO,   PIN_KEEP, 1'b0, SH_NONE,   5'd5,  FL_NEXT,      5'd0};
        step_rom[3]  = {PIN_HI,   PIN_KEEP, 1'b1, SH_NONE,   5'd2,  FL_NEXT,      5'd0};
        step_rom[4]  = {PIN_LO,   PIN_KEEP, 1'b0, SH_NONE,   5'd0,  FL_END,       5'd0};
        step_rom[5]  = {PIN_LO,   PIN_KEEP, 1'b0, SH_NONE,   5'd2,  FL_NEXT,      5'd0};
        step_rom[6]  = {PIN_KEEP, PIN_LO,   1'b0, SH_NONE,   5'd2,  FL_NEXT,      5'd0};
        step_rom[7]  = {PIN_HI,   PIN_KEEP, 1'b0, SH_NONE,   5'd2,  FL_NEXT,      5'd0};
        step_rom[8]  = {PIN_KEEP, PIN_HI,   1'b0, SH_NONE,   5'd0,  FL_END,       5'd0};
        step_rom[9]  = {PIN_LO,   PIN_KEEP, 1'b0, SH_BIT,    5'd3,  FL_NEXT,      5'd0};
        step_rom[10] = {PIN_HI,   PIN_KEEP, 1'b0, SH_NONE,   5'd3,  FL_LOOP_END,  5'd9};
        step_rom[11] = {PIN_HI,   PIN_HI,   1'b0, SH_NONE,   5'd2,  FL_NEXT,      5'd0};
        step_rom[12] = {PIN_KEEP, PIN_LO,   1'b0, SH_LOAD,   5'd0,  FL_NEXT,      5'd0};
        step_rom[13] = {PIN_LO,   PIN_KEEP, 1'b0, SH_BIT,    5'd3,  FL_NEXT,      5'd0};
        step_rom[14] = {PIN_HI,   PIN_KEEP, 1'b0, SH_NONE,   5'd3,  FL_LOOP_NEXT, 5'd13};
        step_rom[15] = {PIN_LO,   PIN_KEEP, 1'b0, SH_NONE,   5'd5,  FL_NEXT,      5'd0};
        step_rom[16] = {PIN_HI,   PIN_KEEP, 1'b1, SH_NONE,   5'd2,  FL_NEXT,      5'd0};
        step_rom[17] = {PIN_LO,   PIN_HI,   1'b0, SH_CLEAR,  5'd0,  FL_NEXT,      5'd0};
        step_rom[18] = {PIN_LO,   PIN_KEEP, 1'b0, SH_SHR,    5'd30, FL_NEXT,      5'd0};
        step_rom[19] = {PIN_HI,   PIN_KEEP, 1'b0, SH_SAMPLE, 5'd30, FL_LOOP_NEXT, 5'd18};
        step_rom[20] = {PIN_LO,   PIN_KEEP, 1'b0, SH_NONE,   5'd5,  FL_NEXT,      5'd0};
        step_rom[21] = {PIN_HI,   PIN_KEEP, 1'b1, SH_NONE,   5'd2,  FL_NEXT,      5'd0};
        step_rom[22] = {PIN_LO,   PIN_KEEP, 1'b0, SH_NONE,   5'd2,  FL_NEXT,      5'd0};
        step_rom[23] = {PIN_KEEP, PIN_LO,   1'b0, SH_NONE,   5'd2,  FL_NEXT,      5'd0};
        step_rom[24] = {PIN_HI,   PIN_KEEP, 1'b0, SH_NONE,   5'd2,  FL_NEXT,      5'd0};
        step_rom[25] = {PIN_KEEP, PIN_HI,   1'b0, SH_NONE,   5'd0,  FL_KEY,       5'd0};
    end

    function automatic logic [DELAY_W-1:0] scaled_delay(input logic [4:0] us);
        int unsigned product;
        product = us * tick_rate;
        if (product > DELAY_MAX) begin
            product = DELAY_MAX;
        end
        return product[DELAY_W-1:0];
    endfunction

    // Walks the pin program until a delay is pending, an acknowledge stalls,
    // or the sequence ends. Returns 1 when a key read has just finished.
    function automatic logic walk_steps(input logic dio_in);
        micro_op_t  op;
        logic [4:0] nxt;
        logic       key_done;
        int         guard;
        for (guard = 0; guard < 1024; guard++) begin
            if (seq_pos >= PROG_LEN) begin
                key_done = (seq_pos == SEQ_KEY);
                seq_pos = SEQ_IDLE;
                return key_done;
            end
            op = step_rom[seq_pos];
            if (op.wait_ack && dio_in) begin
                return 1'b0;
            end
            if (op.clk != PIN_KEEP) begin
                clk_q = (op.clk == PIN_HI);
            end
            if (op.dio != PIN_KEEP) begin
                dio_q = (op.dio == PIN_HI);
            end
            case (op.sh)
                SH_BIT: begin
                    dio_q = shifter[0];
                    shifter = shifter >> 1;
                end
                SH_LOAD: begin
                    shifter = KEY_CMD_BYTE;
                    bit_cnt = '0;
                end
                SH_CLEAR: begin
                    shifter = '0;
                    bit_cnt = '0;
                end
                SH_SHR: shifter = shifter >> 1;
                SH_SAMPLE: begin
                    if (dio_in) begin
                        shifter = shifter | SAMPLE_MSB;
                    end
                end
                default: ;
            endcase
            nxt = seq_pos + 5'd1;
            case (op.flow)
                FL_END: nxt = SEQ_DONE;
                FL_KEY: nxt = SEQ_KEY;
                FL_LOOP_NEXT, FL_LOOP_END: begin
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt < BITS_PER_BYTE) begin
                        nxt = op.target;
                    end else begin
                        bit_cnt = '0;
                        if (op.flow == FL_LOOP_END) begin
                            nxt = SEQ_DONE;
                        end
                    end
                end
                default: ;
            endcase
            seq_pos = nxt;
            delay_left = scaled_delay(op.us);
            if (delay_left != 0) begin
                return 1'b0;
            end
        end
        return 1'b0;
    endfunction

    function automatic out_t predict_pins(input in_t item);
        out_t r;
        logic is_cmd;
        r = '0;
        is_cmd = (item.action >= ACT_START) && (item.action <= ACT_READ);
        if (seq_pos != SEQ_IDLE) begin
            r.rejected = is_cmd;
            if (delay_left != 0) begin
                delay_left = delay_left - 1'b1;
            end
            if (delay_left == 0) begin
                r.key_valid = walk_steps(item.dio_in);
            end
        end else if (is_cmd) begin
            case (item.action)
                ACT_START: seq_pos = ENTRY_START;
                ACT_WRITE: seq_pos = ENTRY_WRITE;
                ACT_ACK:   seq_pos = ENTRY_ACK;
                ACT_STOP:  seq_pos = ENTRY_STOP;
                default:   seq_pos = ENTRY_READ;
            endcase
            bit_cnt = '0;
            shifter = (item.action == ACT_WRITE) ? item.data_byte : 8'h00;
            delay_left = '0;
            r.key_valid = walk_steps(item.dio_in);
        end
        if (r.key_valid) begin
            r.key_code = shifter;
        end
        r.clk_level = clk_q;
        r.dio_level = dio_q;
        r.busy_res = (seq_pos != SEQ_IDLE);
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    // with valid still high, so the next item can follow back to back.
    task automatic send(input logic [2:0] act, input logic [7:0] dbyte, input logic dio);
        in_t item;
        item.action = act;
        item.data_byte = dbyte;
        item.dio_in = dio;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        expected_pins.push_back(predict_pins(item));
        items_sent++;
        @(negedge aclk);
    endtask

    // Feeds ticks until the running sequence is over. Some items are
    // commands or spare codes, which must be refused or treated as ticks.
    task automatic tick_until_idle(input int noise_pct);
        while (seq_pos != SEQ_IDLE) begin
            if ($urandom_range(99) < noise_pct) begin
                send(3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
            end else begin
                send(ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Stops sending and waits until every result is back and the block has
    // had time to finish any work that produces no result.
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_pins.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_rate(input logic [7:0] rate);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= rate;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tick_rate = rate;
    endtask

    // Reset value of the rate is in force until the first write.
    task automatic test_reset_rate();
        send(ACT_START, 8'h00, 1'b0);
        tick_until_idle(10);
    endtask

    // With a zero rate every delay vanishes and commands finish at once,
    // except for acknowledge waits that stall on a high data pin.
    task automatic test_zero_rate();
        set_rate(8'd0);
        send(ACT_TICK, 8'h00, 1'b1);
        send(ACT_SPARE_HI, 8'hFF, 1'b0);
        send(ACT_START, 8'h00, 1'b0);
        send(ACT_WRITE, 8'h00, 1'b0);
        send(ACT_WRITE, 8'hFF, 1'b1);
        send(ACT_WRITE, 8'hA5, 1'b0);
        send(ACT_ACK, 8'h00, 1'b1);
        send(ACT_TICK, 8'h00, 1'b1);
        send(ACT_SPARE_LO, 8'h00, 1'b0);
        send(ACT_STOP, 8'h5A, 1'b1);
        send(ACT_READ, 8'h00, 1'b0);
        send(ACT_READ, 8'hFF, 1'b1);
        send(ACT_WRITE, 8'h3C, 1'b1);
        send(ACT_SPARE_HI, 8'h00, 1'b0);
    endtask

    task automatic test_min_rate();
        set_rate(8'd1);
        send(ACT_WRITE, 8'($urandom_range(0, 255)), 1'b0);
        tick_until_idle(20);
        send(ACT_ACK, 8'h00, 1'b1);
        send(ACT_TICK, 8'h00, 1'b1);
        tick_until_idle(20);
        send(ACT_READ, 8'h00, 1'b0);
        tick_until_idle(15);
        send(ACT_STOP, 8'h00, 1'b0);
        tick_until_idle(30);
    endtask

    task automatic test_random_traffic(input logic [7:0] rate, input int count);
        int      first;
        int      pick;
        logic [2:0] act;
        set_rate(rate);
        first = items_sent;
        while (items_sent - first < count) begin
            if (!tail_phase) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 20;
                    default: idle_pct = 50;
                endcase
            end
            // Key reads are long unless the rate is zero, so they come only then.
            pick = $urandom_range(99);
            if (pick < 10) begin
                act = (pick < 5) ? ACT_TICK : ($urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI);
            end else if (pick < 30) begin
                act = ACT_START;
            end else if (pick < 60) begin
                act = ACT_WRITE;
            end else if (pick < 75) begin
                act = ACT_ACK;
            end else if (pick < 92 || (rate == 0 && pick < 80)) begin
                act = ACT_STOP;
            end else begin
                act = (rate == 0) ? ACT_READ : ACT_STOP;
            end
            send(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            tick_until_idle(tail_phase ? 0 : 12);
        end
    endtask

    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            stall_left <= $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_pins.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("unexpected result at %0t: %p", $realtime, m_data);
                end
            end else begin
                want = expected_pins.pop_front();
                if (m_data !== want) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("mismatch at %0t: expected clk=%b dio=%b busy=%b kv=%b key=%h rej=%b",
                                 $realtime, want.clk_level, want.dio_level, want.busy_res,
                                 want.key_valid, want.key_code, want.rejected);
                        $display("                  actual clk=%b dio=%b busy=%b kv=%b key=%h rej=%b",
                                 m_data.clk_level, m_data.dio_level, m_data.busy_res,
                                 m_data.key_valid, m_data.key_code, m_data.rejected);
                    end
                end
            end
        end
    end

    // Ends the run when no transfer happens on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        seq_pos = SEQ_IDLE;
        delay_left = '0;
        bit_cnt = '0;
        shifter = '0;
        clk_q = 1'b1;
        dio_q = 1'b1;
        tick_rate = TICKS_RESET;
        fail_count = 0;
        items_sent = 0;
        idle_pct = 25;
        tail_phase = 1'b0;
        stall_left = 0;
        quiet_cycles = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_rate();
        test_zero_rate();
        test_min_rate();
        test_random_traffic(8'd0, 40);
        test_random_traffic(8'd1, 20);
        idle_pct = 0;
        tail_phase = 1'b1;
        test_random_traffic(8'd0, 25);
        settle();

        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
